// ===== rtl/spd_pkg.sv =====
// Package for the distance-sorted point table: field widths, command codes
// and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spd_pkg;

    localparam int SLOT_W  = 4;
    localparam int ID_W    = 16;
    localparam int COORD_W = 16;
    localparam int MAXD_W  = 17;
    localparam int DIST_W  = 17;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LIMIT,
        S_RD,
        S_SQX,
        S_SQY,
        S_SUM,
        S_CHK,
        S_SCAN,
        S_RSTART,
        S_RWAIT,
        S_EMIT,
        S_EMPTY
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/spd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module spd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/spd_square.sv =====
// Shared squaring unit: one registered W x W unsigned multiply.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module spd_square #(
    parameter int W = 17
) (
    input  logic           i_clk,
    input  logic [W-1:0]   i_op,
    output logic [2*W-1:0] o_sq
);

    logic [2*W-1:0] r_sq;

    always_ff @(posedge i_clk) begin
        r_sq <= (2*W)'(i_op) * (2*W)'(i_op);
    end

    assign o_sq = r_sq;

endmodule

`default_nettype wire

// ===== rtl/spd_isqrt.sv =====
// Iterative floor square root, one result bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module spd_isqrt #(
    parameter int W = 35
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_value,
    output logic         o_done,
    output logic [W-1:0] o_root
);

    // Highest even bit position that fits in the operand.
    localparam int TOP = ((W - 1) / 2) * 2;

    logic         r_busy;
    logic         r_done;
    logic [W-1:0] r_n;
    logic [W-1:0] r_root;
    logic [W-1:0] r_bit;
    logic [W-1:0] w_trial;
    logic         w_ge;
    logic [W-1:0] w_bit_nx;

    assign w_trial  = r_root + r_bit;
    assign w_ge     = (r_n >= w_trial);
    assign w_bit_nx = r_bit >> 2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (w_bit_nx == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_value;
            r_root <= '0;
            r_bit  <= W'(1) << TOP;
        end else if (r_busy) begin
            if (w_ge) begin
                r_n    <= r_n - w_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= w_bit_nx;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

// ===== rtl/sort_points_by_distance.sv =====
// Distance-sorted point table. A load does not raise busy.
// A query measures all D entries through one shared squaring unit, then
// emits each result after a selection sweep over the table, a bit-serial
// square root and an output state; a query with no match emits a single
// not-found result. Results cannot be stalled. Reset clears the active flags;
// table contents stay undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module sort_points_by_distance #(
    parameter int TABLE_DEPTH = 16,
    parameter int COORD_BITS  = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_command,
    input  logic [spd_pkg::SLOT_W-1:0]       i_slot,
    input  logic [spd_pkg::ID_W-1:0]         i_entry_id,
    input  logic signed [spd_pkg::COORD_W-1:0] i_pos_x,
    input  logic signed [spd_pkg::COORD_W-1:0] i_pos_y,
    input  logic                             i_active,
    input  logic [spd_pkg::MAXD_W-1:0]       i_max_distance,
    input  logic                             i_no_limit,
    output logic                             o_valid,
    output logic [spd_pkg::ID_W-1:0]         o_entry_id_res,
    output logic [spd_pkg::DIST_W-1:0]       o_distance,
    output logic                             o_found,
    output logic                             o_last
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CB    = COORD_BITS;
    localparam int MUL_W = (CB > spd_pkg::MAXD_W) ? CB : spd_pkg::MAXD_W;
    localparam int CMP_W = 2 * MUL_W + 1;
    localparam int TAB_W = spd_pkg::ID_W + 2 * CB;

    spd_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]       r_idx;
    logic [AW-1:0]          r_cidx;
    logic                   r_cvld;
    logic [AW-1:0]          r_best;
    logic [CMP_W-1:0]       r_best_d;
    logic                   r_have;
    logic [CNT_W-1:0]       r_qcnt;
    logic [CNT_W-1:0]       r_ecnt;
    logic [CB-1:0]          r_qx;
    logic [CB-1:0]          r_qy;
    logic                   r_nolim;
    logic [CMP_W-1:0]       r_limit;
    logic [CMP_W-1:0]       r_acc;
    logic [TABLE_DEPTH-1:0] r_active;
    logic [TABLE_DEPTH-1:0] r_qual;
    logic [TABLE_DEPTH-1:0] r_emit;
    logic                   r_valid;
    logic [spd_pkg::ID_W-1:0]   r_out_id;
    logic [spd_pkg::DIST_W-1:0] r_out_dist;
    logic                   r_out_found;
    logic                   r_out_last;

    logic                   w_accept;
    logic                   w_load;
    logic                   w_query;
    logic                   w_slot_ok;
    logic [31:0]            w_slot_ext;
    logic [AW-1:0]          w_slot_addr;
    logic [31:0]            w_x_raw;
    logic [31:0]            w_y_raw;
    logic [CB-1:0]          w_in_x;
    logic [CB-1:0]          w_in_y;
    logic [AW-1:0]          w_idx_a;
    logic                   w_idx_in;
    logic                   w_idx_last;
    logic [TAB_W-1:0]       w_tab_rd;
    logic [spd_pkg::ID_W-1:0] w_tab_id;
    logic [CB-1:0]          w_tab_x;
    logic [CB-1:0]          w_tab_y;
    logic [CB:0]            w_dx;
    logic [CB:0]            w_dy;
    logic [CB:0]            w_dx_abs;
    logic [CB:0]            w_dy_abs;
    logic [MUL_W-1:0]       w_sq_op;
    logic [2*MUL_W-1:0]     w_sq;
    logic [CMP_W-1:0]       w_dist_rd;
    logic                   w_qual_now;
    logic [CNT_W-1:0]       w_qcnt_next;
    logic                   w_cand;
    logic                   w_scan_end;
    logic                   w_last_res;
    logic                   w_root_done;
    logic [CMP_W-1:0]       w_root;
    logic                   w_tab_sel_best;
    logic [AW-1:0]          w_tab_raddr;
    logic                   w_dist_we;
    logic                   w_root_start;
    logic                   w_emit_res;
    logic                   w_emit_empty;

    assign busy     = (r_state != spd_pkg::S_IDLE);
    assign w_accept = start && !busy;
    assign w_load   = w_accept && (i_command == spd_pkg::CMD_LOAD);
    assign w_query  = w_accept && (i_command == spd_pkg::CMD_QUERY);

    assign w_slot_ext  = 32'(i_slot);
    assign w_slot_ok   = (w_slot_ext < 32'(TABLE_DEPTH));
    assign w_slot_addr = w_slot_ext[AW-1:0];

    // Coordinates are the low COORD_BITS of the port, read as two's complement.
    assign w_x_raw = {16'b0, i_pos_x};
    assign w_y_raw = {16'b0, i_pos_y};
    assign w_in_x  = w_x_raw[CB-1:0];
    assign w_in_y  = w_y_raw[CB-1:0];

    assign w_idx_in   = (r_idx < CNT_W'(TABLE_DEPTH));
    assign w_idx_a    = w_idx_in ? r_idx[AW-1:0] : '0;
    assign w_idx_last = (r_idx == CNT_W'(TABLE_DEPTH - 1));

    assign w_tab_id = w_tab_rd[TAB_W-1 -: spd_pkg::ID_W];
    assign w_tab_x  = w_tab_rd[2*CB-1 -: CB];
    assign w_tab_y  = w_tab_rd[CB-1:0];

    assign w_dx     = {w_tab_x[CB-1], w_tab_x} - {r_qx[CB-1], r_qx};
    assign w_dy     = {w_tab_y[CB-1], w_tab_y} - {r_qy[CB-1], r_qy};
    assign w_dx_abs = w_dx[CB] ? (~w_dx + 1'b1) : w_dx;
    assign w_dy_abs = w_dy[CB] ? (~w_dy + 1'b1) : w_dy;

    assign w_qual_now  = r_active[w_idx_a] && (r_nolim || (r_acc <= r_limit));
    assign w_qcnt_next = r_qcnt + CNT_W'(w_qual_now);

    assign w_cand = r_qual[r_cidx] && !r_emit[r_cidx] &&
                    (!r_have || (w_dist_rd < r_best_d));
    assign w_scan_end = !w_idx_in && !r_cvld;
    assign w_last_res = (CNT_W'(r_ecnt + 1'b1) == r_qcnt);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            spd_pkg::S_IDLE: begin
                if (w_query) begin
                    n_state = spd_pkg::S_LIMIT;
                end
            end
            spd_pkg::S_LIMIT: n_state = spd_pkg::S_RD;
            spd_pkg::S_RD:    n_state = spd_pkg::S_SQX;
            spd_pkg::S_SQX:   n_state = spd_pkg::S_SQY;
            spd_pkg::S_SQY:   n_state = spd_pkg::S_SUM;
            spd_pkg::S_SUM:   n_state = spd_pkg::S_CHK;
            spd_pkg::S_CHK: begin
                if (!w_idx_last) begin
                    n_state = spd_pkg::S_RD;
                end else if (w_qcnt_next == '0) begin
                    n_state = spd_pkg::S_EMPTY;
                end else begin
                    n_state = spd_pkg::S_SCAN;
                end
            end
            spd_pkg::S_SCAN: begin
                if (w_scan_end) begin
                    n_state = spd_pkg::S_RSTART;
                end
            end
            spd_pkg::S_RSTART: n_state = spd_pkg::S_RWAIT;
            spd_pkg::S_RWAIT: begin
                if (w_root_done) begin
                    n_state = spd_pkg::S_EMIT;
                end
            end
            spd_pkg::S_EMIT: begin
                n_state = w_last_res ? spd_pkg::S_IDLE : spd_pkg::S_SCAN;
            end
            spd_pkg::S_EMPTY: n_state = spd_pkg::S_IDLE;
            default: n_state = spd_pkg::S_IDLE;
        endcase
    end

    // Control decode.
    always_comb begin
        w_sq_op        = MUL_W'(i_max_distance);
        w_tab_sel_best = 1'b0;
        w_dist_we      = 1'b0;
        w_root_start   = 1'b0;
        w_emit_res     = 1'b0;
        w_emit_empty   = 1'b0;
        case (r_state)
            spd_pkg::S_SQX:    w_sq_op = MUL_W'(w_dx_abs[CB-1:0]);
            spd_pkg::S_SQY:    w_sq_op = MUL_W'(w_dy_abs[CB-1:0]);
            spd_pkg::S_CHK:    w_dist_we = 1'b1;
            spd_pkg::S_RSTART: begin
                w_tab_sel_best = 1'b1;
                w_root_start   = 1'b1;
            end
            spd_pkg::S_RWAIT:  w_tab_sel_best = 1'b1;
            spd_pkg::S_EMIT: begin
                w_tab_sel_best = 1'b1;
                w_emit_res     = 1'b1;
            end
            spd_pkg::S_EMPTY:  w_emit_empty = 1'b1;
            default: ;
        endcase
    end

    assign w_tab_raddr = w_tab_sel_best ? r_best : w_idx_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= spd_pkg::S_IDLE;
            r_active <= '0;
            r_qual   <= '0;
            r_emit   <= '0;
            r_valid  <= 1'b0;
            r_idx    <= '0;
            r_cvld   <= 1'b0;
            r_have   <= 1'b0;
            r_qcnt   <= '0;
            r_ecnt   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= w_emit_res || w_emit_empty;
            if (w_load && w_slot_ok) begin
                r_active[w_slot_addr] <= i_active;
            end
            if (w_query) begin
                r_idx  <= '0;
                r_qcnt <= '0;
                r_ecnt <= '0;
                r_emit <= '0;
            end
            case (r_state)
                spd_pkg::S_CHK: begin
                    r_qual[w_idx_a] <= w_qual_now;
                    r_qcnt          <= w_qcnt_next;
                    if (w_idx_last) begin
                        r_idx  <= '0;
                        r_cvld <= 1'b0;
                        r_have <= 1'b0;
                    end else begin
                        r_idx <= CNT_W'(r_idx + 1'b1);
                    end
                end
                spd_pkg::S_SCAN: begin
                    r_cvld <= w_idx_in;
                    if (w_idx_in) begin
                        r_idx <= CNT_W'(r_idx + 1'b1);
                    end
                    // Strict less-than keeps the lower slot on equal distance.
                    if (r_cvld && w_cand) begin
                        r_have <= 1'b1;
                    end
                end
                spd_pkg::S_EMIT: begin
                    r_emit[r_best] <= 1'b1;
                    r_ecnt         <= CNT_W'(r_ecnt + 1'b1);
                    r_idx          <= '0;
                    r_cvld         <= 1'b0;
                    r_have         <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_qx    <= w_in_x;
            r_qy    <= w_in_y;
            r_nolim <= i_no_limit;
        end
        case (r_state)
            spd_pkg::S_LIMIT: r_limit <= CMP_W'(w_sq);
            spd_pkg::S_SQY:   r_acc   <= CMP_W'(w_sq);
            spd_pkg::S_SUM:   r_acc   <= r_acc + CMP_W'(w_sq);
            spd_pkg::S_SCAN: begin
                r_cidx <= w_idx_a;
                if (r_cvld && w_cand) begin
                    r_best   <= r_cidx;
                    r_best_d <= w_dist_rd;
                end
            end
            default: ;
        endcase
        if (w_emit_res) begin
            r_out_id    <= w_tab_id;
            r_out_dist  <= w_root[spd_pkg::DIST_W-1:0];
            r_out_found <= 1'b1;
            r_out_last  <= w_last_res;
        end else if (w_emit_empty) begin
            r_out_id    <= '0;
            r_out_dist  <= '0;
            r_out_found <= 1'b0;
            r_out_last  <= 1'b1;
        end
    end

    spd_ram #(
        .WIDTH (TAB_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_load && w_slot_ok),
        .i_waddr (w_slot_addr),
        .i_wdata ({i_entry_id, w_in_x, w_in_y}),
        .i_raddr (w_tab_raddr),
        .o_rdata (w_tab_rd)
    );

    spd_ram #(
        .WIDTH (CMP_W),
        .DEPTH (TABLE_DEPTH)
    ) u_dist (
        .i_clk   (i_clk),
        .i_we    (w_dist_we),
        .i_waddr (w_idx_a),
        .i_wdata (r_acc),
        .i_raddr (w_idx_a),
        .o_rdata (w_dist_rd)
    );

    spd_square #(
        .W (MUL_W)
    ) u_square (
        .i_clk (i_clk),
        .i_op  (w_sq_op),
        .o_sq  (w_sq)
    );

    spd_isqrt #(
        .W (CMP_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_value (r_best_d),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    assign o_valid        = r_valid;
    assign o_entry_id_res = r_out_id;
    assign o_distance     = r_out_dist;
    assign o_found        = r_out_found;
    assign o_last         = r_out_last;

endmodule

`default_nettype wire

// ===== verif/sort_points_by_distance_test.sv =====
// Self-checking testbench for sort_points_by_distance: loads point entries,
// runs distance-sorted queries and checks every result strobe against a
// local prediction of the table. Depends on spd_pkg and the block itself.
`timescale 1ns / 1ps

module sort_points_by_distance_test;

    localparam int DEPTH       = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 62;

    typedef struct packed {
        logic                               cmd;
        logic [spd_pkg::SLOT_W-1:0]         slot;
        logic [spd_pkg::ID_W-1:0]           id;
        logic signed [spd_pkg::COORD_W-1:0] x;
        logic signed [spd_pkg::COORD_W-1:0] y;
        logic                               act;
        logic [spd_pkg::MAXD_W-1:0]         maxd;
        logic                               no_lim;
    } t_point_req;

    typedef struct packed {
        logic [spd_pkg::ID_W-1:0]   hit_id;
        logic [spd_pkg::DIST_W-1:0] hit_dist;
        logic                       hit_found;
        logic                       hit_last;
    } t_point_hit;

    // Mirror of the point table and the ordered hits that each query must produce.
    class t_distance_order_tracker;
        logic [spd_pkg::ID_W-1:0] pt_id [DEPTH];
        longint          pt_x [DEPTH];
        longint          pt_y [DEPTH];
        bit              pt_on [DEPTH];
        t_point_hit      pending_hits [$];
        int mismatches, hits_seen, loads, queries, empty_queries, full_queries;

        function new();
            for (int i = 0; i < DEPTH; i++) begin
                pt_id[i] = '0;
                pt_x[i]  = 0;
                pt_y[i]  = 0;
                pt_on[i] = 1'b0;
            end
            mismatches    = 0;
            hits_seen     = 0;
            loads         = 0;
            queries       = 0;
            empty_queries = 0;
            full_queries  = 0;
        endfunction

        static function longint unsigned floor_root(longint unsigned n);
            longint unsigned r;
            longint unsigned trial;
            r = 0;
            for (int b = spd_pkg::DIST_W - 1; b >= 0; b--) begin
                trial = r | (64'd1 << b);
                if (trial * trial <= n) r = trial;
            end
            return r;
        endfunction

        function void add_hit(t_point_hit h);
            pending_hits.insert(pending_hits.size(), h);
        endfunction

        function void predict_query(t_point_req r);
            longint unsigned sq [DEPTH];
            bit              taken [DEPTH];
            int              order [DEPTH];
            longint unsigned bound;
            longint          qx, qy, dx, dy;
            int              pick;
            int              n_hits;
            t_point_hit      h;
            qx = longint'($signed(r.x));
            qy = longint'($signed(r.y));
            bound = longint'(r.maxd) * longint'(r.maxd);
            for (int i = 0; i < DEPTH; i++) begin
                dx = pt_x[i] - qx;
                dy = pt_y[i] - qy;
                sq[i] = dx * dx + dy * dy;
                taken[i] = 1'b0;
            end
            n_hits = 0;
            // Repeated minimum search; the strict compare keeps the lower slot on a tie.
            do begin
                pick = -1;
                for (int i = 0; i < DEPTH; i++) begin
                    if (pt_on[i] && !taken[i] && (r.no_lim || sq[i] <= bound)) begin
                        if (pick < 0 || sq[i] < sq[pick]) pick = i;
                    end
                end
                if (pick >= 0) begin
                    taken[pick] = 1'b1;
                    order[n_hits] = pick;
                    n_hits++;
                end
            end while (pick >= 0);

            if (n_hits == 0) begin
                h = '0;
                h.hit_last = 1'b1;
                add_hit(h);
                empty_queries++;
            end else begin
                for (int k = 0; k < n_hits; k++) begin
                    h.hit_id    = pt_id[order[k]];
                    h.hit_dist  = spd_pkg::DIST_W'(floor_root(sq[order[k]]));
                    h.hit_found = 1'b1;
                    h.hit_last  = (k == n_hits - 1);
                    add_hit(h);
                end
                if (n_hits == DEPTH) full_queries++;
            end
        endfunction

        function void log_request(t_point_req r);
            if (r.cmd == spd_pkg::CMD_LOAD) begin
                pt_id[r.slot] = r.id;
                pt_x[r.slot]  = longint'($signed(r.x));
                pt_y[r.slot]  = longint'($signed(r.y));
                pt_on[r.slot] = r.act;
                loads++;
            end else begin
                predict_query(r);
                queries++;
            end
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d (0x%h), actual %0d (0x%h)",
                         $time, name, want, want, got, got);
                mismatches++;
            end
        endfunction

        function void compare_hit(t_point_hit got);
            t_point_hit want;
            hits_seen++;
            if (pending_hits.size() == 0) begin
                $display({"%0t: unexpected result, expected none, ",
                          "actual id=0x%h distance=%0d found=%b last=%b"},
                         $time, got.hit_id, got.hit_dist, got.hit_found, got.hit_last);
                mismatches++;
                return;
            end
            want = pending_hits.pop_front();
            check_field("entry_id_res", 32'(want.hit_id), 32'(got.hit_id));
            check_field("distance", 32'(want.hit_dist), 32'(got.hit_dist));
            check_field("found", 32'(want.hit_found), 32'(got.hit_found));
            check_field("last", 32'(want.hit_last), 32'(got.hit_last));
        endfunction
    endclass

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    logic                               i_command;
    logic [spd_pkg::SLOT_W-1:0]         i_slot;
    logic [spd_pkg::ID_W-1:0]           i_entry_id;
    logic signed [spd_pkg::COORD_W-1:0] i_pos_x;
    logic signed [spd_pkg::COORD_W-1:0] i_pos_y;
    logic                               i_active;
    logic [spd_pkg::MAXD_W-1:0]         i_max_distance;
    logic                               i_no_limit;
    logic                               o_valid;
    logic [spd_pkg::ID_W-1:0]           o_entry_id_res;
    logic [spd_pkg::DIST_W-1:0]         o_distance;
    logic                               o_found;
    logic                               o_last;

    t_distance_order_tracker board;
    int stall_cycles = 0;

    sort_points_by_distance #(
        .TABLE_DEPTH(DEPTH),
        .COORD_BITS (spd_pkg::COORD_W)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_slot        (i_slot),
        .i_entry_id    (i_entry_id),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_active      (i_active),
        .i_max_distance(i_max_distance),
        .i_no_limit    (i_no_limit),
        .o_valid       (o_valid),
        .o_entry_id_res(o_entry_id_res),
        .o_distance    (o_distance),
        .o_found       (o_found),
        .o_last        (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        t_point_hit got;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            got.hit_id    = o_entry_id_res;
            got.hit_dist  = o_distance;
            got.hit_found = o_found;
            got.hit_last  = o_last;
            board.compare_hit(got);
        end
    end

    // Ends the run if neither a request nor a result moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (start && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d cycles without progress", stall_cycles);
            $display("FAILED: results differ");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_point_req make_load(int slot, int id, int x, int y, bit act);
        t_point_req r;
        r        = '0;
        r.cmd    = spd_pkg::CMD_LOAD;
        r.slot   = spd_pkg::SLOT_W'(slot);
        r.id     = spd_pkg::ID_W'(id);
        r.x      = spd_pkg::COORD_W'(x);
        r.y      = spd_pkg::COORD_W'(y);
        r.act    = act;
        r.maxd   = spd_pkg::MAXD_W'($urandom);
        r.no_lim = 1'($urandom);
        return r;
    endfunction

    function automatic t_point_req make_query(int x, int y, int maxd, bit no_lim);
        t_point_req r;
        r        = '0;
        r.cmd    = spd_pkg::CMD_QUERY;
        r.slot   = spd_pkg::SLOT_W'($urandom);
        r.id     = spd_pkg::ID_W'($urandom);
        r.act    = 1'($urandom);
        r.x      = spd_pkg::COORD_W'(x);
        r.y      = spd_pkg::COORD_W'(y);
        r.maxd   = spd_pkg::MAXD_W'(maxd);
        r.no_lim = no_lim;
        return r;
    endfunction

    // Two in five coordinates sit in a tight cluster so that limits bite and ties occur.
    function automatic int rand_coord();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) return int'($urandom_range(16)) - 8;
        if (pick < 70) return int'($urandom_range(4000)) - 2000;
        if (pick < 80) begin
            case ($urandom_range(3))
                0: return -32768;
                1: return 32767;
                2: return -1;
                default: return 0;
            endcase
        end
        return int'($signed(16'($urandom)));
    endfunction

    function automatic t_point_req random_request();
        int pick;
        int maxd;
        bit no_lim;
        if ($urandom_range(99) < 45) begin
            return make_load($urandom_range(DEPTH - 1), $urandom, rand_coord(),
                             rand_coord(), $urandom_range(99) < 80);
        end
        pick   = $urandom_range(99);
        no_lim = 1'b0;
        maxd   = $urandom;
        if (pick < 20) no_lim = 1'b1;
        else if (pick < 35) maxd = $urandom_range(3);
        else if (pick < 70) maxd = $urandom_range(1 << $urandom_range(spd_pkg::MAXD_W - 1));
        else if (pick >= 85) maxd = (1 << spd_pkg::MAXD_W) - 1;
        return make_query(rand_coord(), rand_coord(), maxd, no_lim);
    endfunction

    task automatic issue(t_point_req r);
        @(negedge i_clk);
        i_command      = r.cmd;
        i_slot         = r.slot;
        i_entry_id     = r.id;
        i_pos_x        = r.x;
        i_pos_y        = r.y;
        i_active       = r.act;
        i_max_distance = r.maxd;
        i_no_limit     = r.no_lim;
        start          = 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.log_request(r);
    endtask

    task automatic idle_sender(int pct);
        while ($urandom_range(99) < pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        start = 1'b0;
        while (board.pending_hits.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int idle_pct [4];
        idle_pct       = '{0, 73, 30, 0};
        board          = new();
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_command      = spd_pkg::CMD_LOAD;
        i_slot         = '0;
        i_entry_id     = '0;
        i_pos_x        = '0;
        i_pos_y        = '0;
        i_active       = 1'b0;
        i_max_distance = '0;
        i_no_limit     = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill every slot so no unwritten entry is ever touched, with corner
        // coordinates and two pairs of equal distances.
        issue(make_load(0, 16'h0000, -32768, -32768, 1'b1));
        issue(make_load(1, 16'hFFFF, 32767, 32767, 1'b1));
        issue(make_load(2, 16'h1234, 0, 0, 1'b1));
        issue(make_load(3, 16'h5555, 0, 0, 1'b1));
        issue(make_load(4, 16'hAAAA, 3, 4, 1'b1));
        issue(make_load(5, 16'h8001, -3, 4, 1'b1));
        issue(make_load(6, 16'h7FFE, 32767, -32768, 1'b1));
        issue(make_load(7, 16'h00FF, -32768, 32767, 1'b1));
        for (int s = 8; s < DEPTH; s++)
            issue(make_load(s, $urandom, s * 100, -s * 37, 1'b1));

        // Far corner with no limit: all sixteen entries, the largest distance last.
        issue(make_query(32767, 32767, 0, 1'b1));
        issue(make_query(0, 0, 0, 1'b0));
        issue(make_query(0, 0, 5, 1'b0));
        issue(make_query(1000, 1000, 1, 1'b0));
        issue(make_query(-32768, -32768, (1 << spd_pkg::MAXD_W) - 1, 1'b0));
        issue(make_load(15, 16'hBEEF, 5, 5, 1'b0));
        issue(make_load(14, 16'hCAFE, 6, 6, 1'b0));
        issue(make_query(-32768, 32767, 0, 1'b1));
        wait_for_results();

        for (int phase = 0; phase < 4; phase++) begin
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                idle_sender(idle_pct[phase]);
                if ($urandom_range(99) < 4) wait_for_results();
                issue(random_request());
            end
            wait_for_results();
        end

        repeat (200) @(posedge i_clk);

        $display("Covered %0d table loads and %0d queries, %0d empty and %0d hitting every slot.",
                 board.loads, board.queries, board.empty_queries, board.full_queries);
        $display("Checked %0d results over four request pacing phases.", board.hits_seen);
        if (board.mismatches == 0 && board.pending_hits.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/spd_pkg.sv
rtl/spd_ram.sv
rtl/spd_square.sv
rtl/spd_isqrt.sv
rtl/sort_points_by_distance.sv
verif/sort_points_by_distance_test.sv
